@@ hdl/lsd_pkg.sv @@
// lsd_pkg: shared types and constants of the lsb stego stream decoder
// depends on nothing; imported by lsb_stego_stream_decoder
package lsd_pkg;

	localparam int MAGIC_MAX  = 8;
	localparam int SIZE_BITS  = 32;
	localparam int EXT_MAX    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = 4;

	localparam logic [15:0] HEADER_SKIP_RST = 16'd54;
	localparam logic [3:0]  MAGIC_LEN_RST   = 4'd2;
	localparam logic [63:0] MAGIC_WORD_RST  = 64'd8998;
	localparam logic [5:0]  EXT_LIMIT_RST   = 6'd20;
	localparam logic [31:0] SIZE_LIMIT_RST  = 32'd10000000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAGIC_WORD  = 3'd0,
		CFG_MAGIC_LEN   = 3'd1,
		CFG_HEADER_SKIP = 3'd2,
		CFG_EXT_LIMIT   = 3'd3,
		CFG_SIZE_LIMIT  = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		RK_EXT_LEN     = 3'd0,
		RK_EXT_BYTE    = 3'd1,
		RK_SECRET_SIZE = 3'd2,
		RK_SECRET_BYTE = 3'd3,
		RK_ERROR       = 3'd4
	} res_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_MAGIC     = 3'd1,
		ERR_EXT_LEN   = 3'd2,
		ERR_SIZE      = 3'd3,
		ERR_TRUNCATED = 3'd4
	} err_code_t;

	typedef struct packed {
		logic      run_end;
		logic      final_secret_byte;
		err_code_t error_code;
		logic [31:0] result_value;
		res_kind_t result_kind;
	} res_t;

endpackage

@@ hdl/lsb_stego_stream_decoder.sv @@
// lsb_stego_stream_decoder: top level, lsb extraction, field decode, result queue
// depends on lsd_pkg
//
// queue: each result is written into the result queue on its input transfer and is offered
//   on the master side once it reaches the head of that queue
// throughput: one input item per cycle while the four-entry result queue has two entries free,
//   so that an item that gives two results (a word result followed by a truncation error) fits
// reset: arst_n clears decode state and the queue, and loads the register defaults
module lsb_stego_stream_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	// cfg write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lsd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lsd_pkg::CFG_DATA_W-1:0]  cfg_data,
	// image byte stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [lsd_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [7:0] image_byte
	input  logic                            s_axis_tuser,   // [0] kind
	input  logic                            s_axis_tlast,   // end_of_image
	// result stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [lsd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [31:0] result_value, [34:32] error_code
	output logic [lsd_pkg::OUT_USER_W-1:0]  m_axis_tuser,   // [2:0] result_kind, [3] final_secret_byte
	output logic                            m_axis_tlast    // run_end
);
	import lsd_pkg::*;

	typedef enum logic [2:0] {
		PH_SKIP, PH_MAGIC, PH_EXTLEN, PH_EXT, PH_SIZE, PH_DATA, PH_DONE, PH_FAIL
	} phase_t;

	// registers
	logic [63:0] magic_word_q;
	logic [3:0]  magic_len_q;
	logic [15:0] header_skip_q;
	logic [5:0]  ext_limit_q;
	logic [31:0] size_limit_q;

	// decode state
	phase_t      phase_q, phase_d;
	logic [15:0] skip_cnt_q, skip_cnt_d;
	logic [4:0]  bit_cnt_q, bit_cnt_d;
	logic [31:0] shift_q, shift_d;
	logic [31:0] item_cnt_q, item_cnt_d;
	logic [4:0]  ext_len_q, ext_len_d;
	logic [31:0] secret_size_q, secret_size_d;

	// result queue
	res_t        fifo_q [4];
	logic [1:0]  head_q;
	logic [2:0]  count_q;

	logic        in_xfer, out_xfer;
	logic        word_vld, trunc_vld;
	res_t        word_res, trunc_res, first_res, second_res;
	logic [1:0]  push_n;
	logic [1:0]  tail;

	logic [3:0]  mlen_eff;
	logic [5:0]  ext_lim_eff;
	logic [4:0]  need_m1;
	logic [31:0] shift_new, word, item_inc;
	logic [7:0]  magic_exp;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (count_q <= 3'd2);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_xfer      = m_axis_tvalid && m_axis_tready;

	assign mlen_eff    = (magic_len_q > 4'(MAGIC_MAX)) ? 4'(MAGIC_MAX) : magic_len_q;
	assign ext_lim_eff = (ext_limit_q > 6'(EXT_MAX)) ? 6'(EXT_MAX) : ext_limit_q;
	assign item_inc    = item_cnt_q + 32'd1;
	assign shift_new   = {shift_q[30:0], s_axis_tdata[0]};
	assign magic_exp   = 8'(magic_word_q >> {item_cnt_q[2:0], 3'b000});

	always_comb begin
		logic consumed;
		phase_t ph;
		consumed      = 1'b0;
		ph            = phase_q;
		phase_d       = phase_q;
		skip_cnt_d    = skip_cnt_q;
		bit_cnt_d     = bit_cnt_q;
		shift_d       = shift_q;
		item_cnt_d    = item_cnt_q;
		ext_len_d     = ext_len_q;
		secret_size_d = secret_size_q;
		word_vld      = 1'b0;
		trunc_vld     = 1'b0;
		need_m1       = 5'd7;
		word          = '0;
		word_res      = '{run_end: 1'b0, final_secret_byte: 1'b0, error_code: ERR_NONE,
			result_value: 32'd0, result_kind: RK_EXT_LEN};
		trunc_res     = '{run_end: 1'b1, final_secret_byte: 1'b0, error_code: ERR_TRUNCATED,
			result_value: 32'd0, result_kind: RK_ERROR};

		if (s_axis_tuser) begin
			phase_d       = PH_SKIP;
			skip_cnt_d    = '0;
			bit_cnt_d     = '0;
			shift_d       = '0;
			item_cnt_d    = '0;
			ext_len_d     = '0;
			secret_size_d = '0;
		end else if (phase_q != PH_DONE && phase_q != PH_FAIL) begin
			if (ph == PH_SKIP) begin
				if (skip_cnt_q < header_skip_q) begin
					skip_cnt_d = skip_cnt_q + 16'd1;
					consumed   = 1'b1;
				end else begin
					ph         = PH_MAGIC;
					item_cnt_d = '0;
				end
			end
			if (!consumed) begin
				if (ph == PH_MAGIC && item_cnt_d >= {28'd0, mlen_eff}) begin
					ph         = PH_EXTLEN;
					item_cnt_d = '0;
				end
				need_m1 = (ph == PH_EXTLEN || ph == PH_SIZE) ? 5'(SIZE_BITS - 1) : 5'd7;
				word    = (need_m1 == 5'd7) ? {24'd0, shift_new[7:0]} : shift_new;
				if (bit_cnt_q >= need_m1) begin
					shift_d   = '0;
					bit_cnt_d = '0;
					unique case (ph)
						PH_MAGIC: begin
							if (word[7:0] != magic_exp) begin
								ph       = PH_FAIL;
								word_vld = 1'b1;
								word_res.result_kind = RK_ERROR;
								word_res.error_code  = ERR_MAGIC;
							end else if (item_inc >= {28'd0, mlen_eff}) begin
								ph         = PH_EXTLEN;
								item_cnt_d = '0;
							end else begin
								item_cnt_d = item_inc;
							end
						end
						PH_EXTLEN: begin
							word_vld = 1'b1;
							word_res.result_value = word;
							if (word >= 32'd1 && word < {26'd0, ext_lim_eff}) begin
								ext_len_d  = word[4:0];
								ph         = PH_EXT;
								item_cnt_d = '0;
								word_res.result_kind = RK_EXT_LEN;
							end else begin
								ph = PH_FAIL;
								word_res.result_kind = RK_ERROR;
								word_res.error_code  = ERR_EXT_LEN;
							end
						end
						PH_EXT: begin
							word_vld = 1'b1;
							word_res.result_value = word;
							word_res.result_kind  = RK_EXT_BYTE;
							if (item_inc >= {27'd0, ext_len_q}) begin
								ph         = PH_SIZE;
								item_cnt_d = '0;
							end else begin
								item_cnt_d = item_inc;
							end
						end
						PH_SIZE: begin
							word_vld = 1'b1;
							word_res.result_value = word;
							if (word >= 32'd1 && word <= size_limit_q) begin
								secret_size_d = word;
								ph            = PH_DATA;
								item_cnt_d    = '0;
								word_res.result_kind = RK_SECRET_SIZE;
							end else begin
								ph = PH_FAIL;
								word_res.result_kind = RK_ERROR;
								word_res.error_code  = ERR_SIZE;
							end
						end
						PH_DATA: begin
							word_vld   = 1'b1;
							item_cnt_d = item_inc;
							word_res.result_value = word;
							word_res.result_kind  = RK_SECRET_BYTE;
							if (item_inc >= secret_size_q) begin
								ph = PH_DONE;
								word_res.final_secret_byte = 1'b1;
							end
						end
						default: ;
					endcase
				end else begin
					shift_d   = shift_new;
					bit_cnt_d = bit_cnt_q + 5'd1;
				end
			end
			if (s_axis_tlast && ph != PH_DONE && ph != PH_FAIL) begin
				trunc_vld = 1'b1;
				ph        = PH_FAIL;
			end
			phase_d = ph;
		end

		word_res.run_end = !trunc_vld;
		first_res  = word_vld ? word_res : trunc_res;
		second_res = trunc_res;
		push_n     = 2'(word_vld) + 2'(trunc_vld);
	end

	assign tail = head_q + count_q[1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_word_q  <= MAGIC_WORD_RST;
			magic_len_q   <= MAGIC_LEN_RST;
			header_skip_q <= HEADER_SKIP_RST;
			ext_limit_q   <= EXT_LIMIT_RST;
			size_limit_q  <= SIZE_LIMIT_RST;
			phase_q       <= PH_SKIP;
			skip_cnt_q    <= '0;
			bit_cnt_q     <= '0;
			shift_q       <= '0;
			item_cnt_q    <= '0;
			ext_len_q     <= '0;
			secret_size_q <= '0;
			head_q        <= '0;
			count_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_MAGIC_WORD:  magic_word_q  <= cfg_data;
					CFG_MAGIC_LEN:   magic_len_q   <= cfg_data[3:0];
					CFG_HEADER_SKIP: header_skip_q <= cfg_data[15:0];
					CFG_EXT_LIMIT:   ext_limit_q   <= cfg_data[5:0];
					CFG_SIZE_LIMIT:  size_limit_q  <= cfg_data[31:0];
					default: ;
				endcase
			end
			if (in_xfer) begin
				phase_q       <= phase_d;
				skip_cnt_q    <= skip_cnt_d;
				bit_cnt_q     <= bit_cnt_d;
				shift_q       <= shift_d;
				item_cnt_q    <= item_cnt_d;
				ext_len_q     <= ext_len_d;
				secret_size_q <= secret_size_d;
			end
			if (out_xfer)
				head_q <= head_q + 2'd1;
			count_q <= count_q + (in_xfer ? {1'b0, push_n} : 3'd0) - {2'd0, out_xfer};
		end
	end

	// queue entries carry payload only
	always_ff @(posedge clk) begin
		if (in_xfer && push_n != 2'd0)
			fifo_q[tail] <= first_res;
		if (in_xfer && push_n == 2'd2)
			fifo_q[tail + 2'd1] <= second_res;
	end

	assign m_axis_tvalid = (count_q != 3'd0);
	assign m_axis_tdata  = {5'd0, fifo_q[head_q].error_code, fifo_q[head_q].result_value};
	assign m_axis_tuser  = {fifo_q[head_q].final_secret_byte, fifo_q[head_q].result_kind};
	assign m_axis_tlast  = fifo_q[head_q].run_end;

endmodule

@@ tb/sv/lsb_stego_stream_decoder_tb.sv @@
`timescale 1ns / 1ps
// lsb_stego_stream_decoder_tb: self-checking bench, streams cover images with hidden payloads
// through the decoder and checks each result transfer against a cycle-free decode predictor
// depends on lsd_pkg and lsb_stego_stream_decoder
module lsb_stego_stream_decoder_tb;
	import lsd_pkg::*;

	localparam int ITEM_GOAL     = 2000;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int SETTLE_CYCLES = 4;

	typedef enum logic [2:0] {
		DP_SKIP, DP_MAGIC, DP_EXT_LEN, DP_EXT, DP_SIZE, DP_DATA, DP_DONE, DP_FAIL
	} dec_phase_t;

	typedef enum int {
		IMG_GOOD, IMG_BAD_MAGIC, IMG_BAD_EXT, IMG_BAD_SIZE, IMG_CUT, IMG_NOISE
	} image_mode_t;

	typedef struct packed {
		logic       restart;
		logic [7:0] pixel;
		logic       eoi;
	} cover_item_t;

	class stego_scoreboard;
		logic [63:0] magic_word;
		logic [3:0]  magic_len;
		logic [15:0] header_skip;
		logic [5:0]  ext_limit;
		logic [31:0] size_limit;
		dec_phase_t  phase;
		logic [15:0] skip_cnt;
		logic [4:0]  bit_cnt;
		logic [31:0] shift_reg;
		logic [31:0] item_cnt;
		logic [4:0]  ext_len;
		logic [31:0] secret_size;
		res_t        owed_results[$];
		res_t        step_results[$];
		int          errors;
		int          live_items;
		int          kind_seen[5];

		function new();
			magic_word  = MAGIC_WORD_RST;
			magic_len   = MAGIC_LEN_RST;
			header_skip = HEADER_SKIP_RST;
			ext_limit   = EXT_LIMIT_RST;
			size_limit  = SIZE_LIMIT_RST;
			errors      = 0;
			live_items  = 0;
			foreach (kind_seen[i]) kind_seen[i] = 0;
			restart_decode();
		endfunction

		function void restart_decode();
			phase       = DP_SKIP;
			skip_cnt    = '0;
			bit_cnt     = '0;
			shift_reg   = '0;
			item_cnt    = '0;
			ext_len     = '0;
			secret_size = '0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [63:0] value);
			case (idx)
			CFG_MAGIC_WORD:  magic_word  = value;
			CFG_MAGIC_LEN:   magic_len   = value[3:0];
			CFG_HEADER_SKIP: header_skip = value[15:0];
			CFG_EXT_LIMIT:   ext_limit   = value[5:0];
			CFG_SIZE_LIMIT:  size_limit  = value[31:0];
			default: ;
			endcase
		endfunction

		function int unsigned magic_eff();
			return (magic_len > MAGIC_MAX) ? MAGIC_MAX : magic_len;
		endfunction

		function void emit(res_kind_t kind, logic [31:0] value, err_code_t code, logic fin);
			res_t r;
			r.result_kind       = kind;
			r.result_value      = value;
			r.error_code        = code;
			r.final_secret_byte = fin;
			r.run_end           = 1'b0;
			step_results.push_back(r);
		endfunction

		function void fail_with(err_code_t code, logic [31:0] value);
			phase = DP_FAIL;
			emit(RK_ERROR, value, code, 1'b0);
		endfunction

		function void take_word(logic [31:0] w);
			logic [5:0] lim;
			case (phase)
			DP_MAGIC: begin
				if (w != {24'b0, magic_word[item_cnt[2:0] * 8 +: 8]}) begin
					fail_with(ERR_MAGIC, 32'd0);
					return;
				end
				item_cnt++;
				if (item_cnt >= magic_eff()) begin
					phase    = DP_EXT_LEN;
					item_cnt = '0;
				end
			end
			DP_EXT_LEN: begin
				lim = (ext_limit > EXT_MAX) ? 6'(EXT_MAX) : ext_limit;
				if (w >= 1 && w < lim) begin
					ext_len = w[4:0];
					emit(RK_EXT_LEN, w, ERR_NONE, 1'b0);
					phase    = DP_EXT;
					item_cnt = '0;
				end else begin
					fail_with(ERR_EXT_LEN, w);
				end
			end
			DP_EXT: begin
				emit(RK_EXT_BYTE, w, ERR_NONE, 1'b0);
				item_cnt++;
				if (item_cnt >= ext_len) begin
					phase    = DP_SIZE;
					item_cnt = '0;
				end
			end
			DP_SIZE: begin
				if (w >= 1 && w <= size_limit) begin
					secret_size = w;
					emit(RK_SECRET_SIZE, w, ERR_NONE, 1'b0);
					phase    = DP_DATA;
					item_cnt = '0;
				end else begin
					fail_with(ERR_SIZE, w);
				end
			end
			DP_DATA: begin
				item_cnt++;
				emit(RK_SECRET_BYTE, w, ERR_NONE, item_cnt >= secret_size);
				if (item_cnt >= secret_size) phase = DP_DONE;
			end
			default: ;
			endcase
		endfunction

		function void note_input(logic restart, logic [7:0] pixel, logic eoi);
			bit          consumed;
			int          need;
			logic [31:0] w;
			res_t        r;
			consumed = 1'b0;
			step_results.delete();
			if (restart) begin
				restart_decode();
				return;
			end
			if (phase == DP_DONE || phase == DP_FAIL) return;
			live_items++;
			if (phase == DP_SKIP) begin
				if (skip_cnt < header_skip) begin
					skip_cnt++;
					consumed = 1'b1;
				end else begin
					phase    = DP_MAGIC;
					item_cnt = '0;
				end
			end
			if (!consumed) begin
				if (phase == DP_MAGIC && item_cnt >= magic_eff()) begin
					phase    = DP_EXT_LEN;
					item_cnt = '0;
				end
				need      = (phase == DP_EXT_LEN || phase == DP_SIZE) ? SIZE_BITS : 8;
				shift_reg = {shift_reg[30:0], pixel[0]};
				if (bit_cnt + 1 >= need) begin
					w         = (need == 32) ? shift_reg : {24'b0, shift_reg[7:0]};
					shift_reg = '0;
					bit_cnt   = '0;
					take_word(w);
				end else begin
					bit_cnt++;
				end
			end
			if (eoi && phase != DP_DONE && phase != DP_FAIL) fail_with(ERR_TRUNCATED, 32'd0);
			if (step_results.size() > 0) begin
				r         = step_results[step_results.size() - 1];
				r.run_end = 1'b1;
				step_results[step_results.size() - 1] = r;
			end
			foreach (step_results[i]) owed_results.push_back(step_results[i]);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			end
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] tdata, logic [OUT_USER_W-1:0] tuser,
				logic tlast);
			res_t want;
			if (owed_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got kind %0h value %0h",
					$time, tuser[2:0], tdata[31:0]);
				return;
			end
			want = owed_results.pop_front();
			compare_field("result_kind", 32'(want.result_kind), 32'(tuser[2:0]));
			compare_field("result_value", want.result_value, tdata[31:0]);
			compare_field("error_code", 32'(want.error_code), 32'(tdata[34:32]));
			compare_field("final_secret_byte", 32'(want.final_secret_byte), 32'(tuser[3]));
			compare_field("run_end", 32'(want.run_end), 32'(tlast));
			compare_field("tdata padding", 32'd0, 32'(tdata[OUT_DATA_W-1:35]));
			if (tuser[2:0] <= RK_ERROR) kind_seen[tuser[2:0]]++;
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic                  m_axis_tlast;

	stego_scoreboard sb;
	cover_item_t     cover_q[$];
	bit              steady = 1'b0;
	int              cycles = 0;
	int              sent_items = 0;

	lsb_stego_stream_decoder dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	always @(negedge clk) m_axis_tready <= steady || ($urandom_range(99) >= 10);

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	task automatic write_cfg(cfg_idx_t idx, logic [63:0] value);
		logic [63:0] junk;
		int          width;
		case (idx)
		CFG_MAGIC_WORD:  width = 64;
		CFG_MAGIC_LEN:   width = 4;
		CFG_HEADER_SKIP: width = 16;
		CFG_EXT_LIMIT:   width = 6;
		default:         width = 32;
		endcase
		junk = {$urandom, $urandom};
		// bits above the register width must be dropped
		if (width < 64 && $urandom_range(1)) value = value | (junk << width);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, value);
		@(negedge clk);
	endtask

	task automatic push_byte(cover_item_t it);
		while (!steady && $urandom_range(99) < 10) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= it.pixel;
		s_axis_tuser  <= it.restart;
		s_axis_tlast  <= it.eoi;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_input(it.restart, it.pixel, it.eoi);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic drain(int limit);
		int waited;
		waited = 0;
		s_axis_tvalid <= 1'b0;
		while (sb.owed_results.size() != 0 && waited < limit) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// hidden bits ride in the lsb, msb first; the upper pixel bits are noise
	function automatic void put_word(logic [31:0] w, int nbits);
		cover_item_t it;
		logic [7:0]  noise;
		for (int i = nbits - 1; i >= 0; i--) begin
			noise      = 8'($urandom);
			it.restart = 1'b0;
			it.pixel   = {noise[7:1], w[i]};
			it.eoi     = 1'b0;
			cover_q.push_back(it);
		end
	endfunction

	task automatic send_image(image_mode_t mode);
		cover_item_t it;
		logic [31:0] lim, ext_n, size_n, cap;
		logic [7:0]  mb;
		int          mlen, bad_at, cut, n, r;
		bit          ext_ok, size_ok;
		cover_q.delete();
		if (mode == IMG_NOISE) begin
			n = $urandom_range(1, 40);
			repeat (n) begin
				it.restart = ($urandom_range(29) == 0);
				it.pixel   = 8'($urandom);
				it.eoi     = ($urandom_range(19) == 0);
				cover_q.push_back(it);
			end
		end else begin
			it.restart = 1'b1;
			it.pixel   = 8'($urandom);
			it.eoi     = 1'($urandom);
			cover_q.push_back(it);
			repeat (sb.header_skip) put_word($urandom, 1);
			mlen   = sb.magic_eff();
			bad_at = (mlen > 0) ? $urandom_range(mlen - 1) : 0;
			for (int i = 0; i < mlen; i++) begin
				mb = sb.magic_word[i * 8 +: 8];
				if (mode == IMG_BAD_MAGIC && i == bad_at) mb = mb ^ (8'd1 << $urandom_range(7));
				put_word({24'b0, mb}, 8);
			end
			lim = (sb.ext_limit > EXT_MAX) ? EXT_MAX : sb.ext_limit;
			if (mode != IMG_BAD_EXT && lim >= 2) begin
				ext_n = $urandom_range(1, lim - 1);
			end else begin
				case ($urandom_range(3))
				0:       ext_n = 32'd0;
				1:       ext_n = lim;
				2:       ext_n = {1'b1, 31'($urandom)};
				default: ext_n = $urandom;
				endcase
			end
			ext_ok = (ext_n >= 1 && ext_n < lim);
			put_word(ext_n, 32);
			if (ext_ok) begin
				repeat (ext_n) put_word($urandom, 8);
				cap = ($urandom_range(9) == 0) ? 40 : 8;
				if (cap > sb.size_limit) cap = sb.size_limit;
				if (mode != IMG_BAD_SIZE && cap >= 1)
					size_n = $urandom_range(1, cap);
				else if (sb.size_limit == '1 || $urandom_range(2) == 0)
					size_n = 32'd0;
				else
					size_n = $urandom_range(sb.size_limit + 1, 32'hffff_ffff);
				size_ok = (size_n >= 1 && size_n <= sb.size_limit);
				put_word(size_n, 32);
				if (size_ok) repeat (size_n) put_word($urandom, 8);
			end
			r = $urandom_range(3);
			if (r == 0) repeat ($urandom_range(1, 3)) put_word($urandom, 1);
			if (mode == IMG_CUT) begin
				cut = $urandom_range(1, cover_q.size() - 1);
				while (cover_q.size() > cut + 1) void'(cover_q.pop_back());
				r = $urandom_range(1) ? 1 : 3;
			end
			// no end marker leaves the image open for the next restart
			if (r != 3) begin
				it     = cover_q[cover_q.size() - 1];
				it.eoi = 1'b1;
				cover_q[cover_q.size() - 1] = it;
			end
		end
		foreach (cover_q[i]) push_byte(cover_q[i]);
	endtask

	initial begin
		int          p, n, r, images, settings;
		image_mode_t mode;
		sb            = new();
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_MAGIC_WORD;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		s_axis_tlast  = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// restart with every other field set, pixel extremes in the header, end during skip,
		// bytes after an error, restart out of the error
		push_byte('{1'b1, 8'hff, 1'b1});
		push_byte('{1'b0, 8'h00, 1'b0});
		push_byte('{1'b0, 8'hff, 1'b0});
		push_byte('{1'b0, 8'h80, 1'b0});
		push_byte('{1'b0, 8'h7f, 1'b0});
		push_byte('{1'b0, 8'h01, 1'b1});
		push_byte('{1'b0, 8'hfe, 1'b1});
		push_byte('{1'b1, 8'h00, 1'b0});
		push_byte('{1'b0, 8'h55, 1'b1});
		push_byte('{1'b1, 8'haa, 1'b0});
		drain(CYCLE_LIMIT);

		images   = 0;
		settings = 1;
		for (p = 0; p < 5 || sent_items < ITEM_GOAL; p++) begin
			steady = (p % 3 == 1);
			case (p)
			0: ;
			1: begin
				write_cfg(CFG_MAGIC_LEN, 64'd0);
				write_cfg(CFG_HEADER_SKIP, 64'd0);
				write_cfg(CFG_EXT_LIMIT, 64'd32);
				write_cfg(CFG_SIZE_LIMIT, 64'd1);
			end
			2: begin
				write_cfg(CFG_MAGIC_WORD, '1);
				write_cfg(CFG_MAGIC_LEN, 64'd8);
				write_cfg(CFG_HEADER_SKIP, 64'd1);
				write_cfg(CFG_EXT_LIMIT, 64'd1);
				write_cfg(CFG_SIZE_LIMIT, 64'hffff_ffff);
			end
			3: begin
				write_cfg(CFG_MAGIC_WORD, 64'd0);
				write_cfg(CFG_MAGIC_LEN, 64'd15);
				write_cfg(CFG_HEADER_SKIP, 64'd2);
				write_cfg(CFG_EXT_LIMIT, 64'd63);
				write_cfg(CFG_SIZE_LIMIT, 64'd5);
			end
			4: begin
				write_cfg(CFG_HEADER_SKIP, 64'd100);
				write_cfg(CFG_MAGIC_LEN, 64'd1);
				write_cfg(CFG_EXT_LIMIT, 64'd2);
				write_cfg(CFG_SIZE_LIMIT, 64'd2);
			end
			default: begin
				write_cfg(CFG_MAGIC_WORD, {$urandom, $urandom});
				write_cfg(CFG_MAGIC_LEN, 64'(($urandom_range(9) == 0) ?
					$urandom_range(9, 15) : $urandom_range(8)));
				write_cfg(CFG_HEADER_SKIP, 64'($urandom_range(12)));
				write_cfg(CFG_EXT_LIMIT, 64'(($urandom_range(9) == 0) ?
					$urandom_range(33, 63) : $urandom_range(1, 32)));
				write_cfg(CFG_SIZE_LIMIT, 64'(($urandom_range(3) == 0) ?
					$urandom : $urandom_range(1, 10)));
			end
			endcase
			cfg_valid <= 1'b0;
			if (p != 0) settings++;
			// a long header skip runs once with a single clean image
			n = (p == 4) ? 1 : (p < 4) ? $urandom_range(1, 2) : $urandom_range(2, 4);
			repeat (n) begin
				r = $urandom_range(99);
				if (p == 4 || r < 55) mode = IMG_GOOD;
				else if (r < 63)      mode = IMG_BAD_MAGIC;
				else if (r < 71)      mode = IMG_BAD_EXT;
				else if (r < 79)      mode = IMG_BAD_SIZE;
				else if (r < 93)      mode = IMG_CUT;
				else                  mode = IMG_NOISE;
				send_image(mode);
				images++;
			end
			drain(CYCLE_LIMIT);
		end

		drain(5000);
		if (sb.owed_results.size() != 0) begin
			sb.errors++;
			$display("%0t: results missing at end, expected %0d more, got none",
				$time, sb.owed_results.size());
		end
		$display("decoded %0d images under %0d register settings, %0d bytes sent, %0d decoded",
			images, settings, sent_items, sb.live_items);
		$display("checked %0d ext lengths, %0d ext bytes, %0d sizes, %0d secret bytes, %0d errors",
			sb.kind_seen[RK_EXT_LEN], sb.kind_seen[RK_EXT_BYTE], sb.kind_seen[RK_SECRET_SIZE],
			sb.kind_seen[RK_SECRET_BYTE], sb.kind_seen[RK_ERROR]);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
